### hw/rtl/rie_pkg.sv
// Shared opcodes, function codes and controller/datapath interface types of the execute step.
package rie_pkg;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_BLEZ    = 6'd6;
	localparam logic [5:0] OP_BGTZ    = 6'd7;
	localparam logic [5:0] OP_ADDI    = 6'd8;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_SW      = 6'd43;

	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_JR      = 6'd8;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_MFHI    = 6'd16;
	localparam logic [5:0] FN_MFLO    = 6'd18;
	localparam logic [5:0] FN_MULT    = 6'd24;
	localparam logic [5:0] FN_DIV     = 6'd26;
	localparam logic [5:0] FN_ADD     = 6'd32;
	localparam logic [5:0] FN_SUB     = 6'd34;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_OR      = 6'd37;
	localparam logic [5:0] FN_XOR     = 6'd38;
	localparam logic [5:0] FN_SLT     = 6'd42;

	localparam logic [4:0] LINK_REG = 5'd31;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic exec;
		logic div_start;
		logic div_signed;
		logic ld_maddr;
		logic mem_rd;
		logic commit;
		logic clr_en;
	} rie_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_div;
		logic div_zero;
		logic is_mem;
		logic addr_mod;
		logic div_done;
		logic clr_last;
	} rie_sts_t;

endpackage

### hw/rtl/risc_integer_execute_step_top.sv
// Top level of the integer execute step: controller and datapath.
//
// Each request carries one 32-bit instruction word, fetched at the PC that the
// previous result reported, and produces exactly one result with the next PC,
// the register write, the memory access and HI/LO after the instruction.
// Register reads happen as the request is accepted; an instruction then passes
// the execute state and commits in the done state once the output register is
// free, and there the next request may already be accepted. ALU, branch, jump,
// MULT and MFHI/MFLO requests go straight from execute to done. LW and SW add
// the memory state for the registered data memory read. DIV runs the iterative
// divider between execute and done; a zero divisor skips it. When DATA_WORDS is
// not a power of two, LW and SW also reduce the word index by a reciprocal
// multiplication in the address state before the memory state. After reset the
// data memory is cleared one word per cycle, so no request is accepted until
// every word has been cleared. A finished result waits in the output register
// while the block already works on the next request.
module risc_integer_execute_step_top #(
	parameter int DATA_WORDS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   instruction_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   next_pc,
	output logic                          reg_write,
	output logic [4:0]                    reg_index,
	output logic signed [31:0]            reg_value,
	output logic                          mem_write,
	output logic [$clog2(DATA_WORDS)-1:0] mem_word_address,
	output logic signed [31:0]            mem_data,
	output logic signed [31:0]            hi_value,
	output logic signed [31:0]            lo_value,
	output logic                          divide_by_zero
);

	rie_pkg::rie_cmd_t cmd;
	rie_pkg::rie_sts_t sts;

	// The controller owns the handshakes and the sequence of each instruction.
	rie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds all architectural state and the result registers.
	rie_dp #(
		.DATA_WORDS (DATA_WORDS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.instruction_word (instruction_word),
		.next_pc          (next_pc),
		.reg_write        (reg_write),
		.reg_index        (reg_index),
		.reg_value        (reg_value),
		.mem_write        (mem_write),
		.mem_word_address (mem_word_address),
		.mem_data         (mem_data),
		.hi_value         (hi_value),
		.lo_value         (lo_value),
		.divide_by_zero   (divide_by_zero)
	);

endmodule

### hw/rtl/rie_div.sv
// Iterative restoring divider, one quotient bit per cycle, signed or unsigned.
module rie_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        sgn,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot,
	output logic [31:0] rem
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] n_q;
	logic [31:0] d_q;
	logic [31:0] r_q;
	logic        negq_q;
	logic        negr_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {r_q, n_q[31]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= (sgn && dividend[31]) ? (32'd0 - dividend) : dividend;
			d_q    <= (sgn && divisor[31]) ? (32'd0 - divisor) : divisor;
			r_q    <= '0;
			negq_q <= sgn && (dividend[31] ^ divisor[31]);
			negr_q <= sgn && dividend[31];
		end else if (busy_q) begin
			// The trial remainder never exceeds twice the divisor, so 32 bits hold the result.
			if (!diff[32]) begin
				r_q <= diff[31:0];
				n_q <= {n_q[30:0], 1'b1};
			end else begin
				r_q <= trial[31:0];
				n_q <= {n_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = negq_q ? (32'd0 - n_q) : n_q;
	assign rem  = negr_q ? (32'd0 - r_q) : r_q;

endmodule

### hw/rtl/rie_ctrl.sv
// Controller state machine that sequences memory clear, accept, execute, divide, address reduction, memory and commit.
module rie_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rie_pkg::rie_sts_t sts,
	output rie_pkg::rie_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_EXEC  = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_AMOD  = 7'b0010000,
		ST_MEM   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} rie_state_t;

	rie_state_t state_q;
	rie_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.is_div && !sts.div_zero) begin
					cmd.div_start  = 1'b1;
					cmd.div_signed = 1'b1;
					state_d        = ST_DIV;
				end else if (sts.is_mem) begin
					if (sts.addr_mod) begin
						state_d = ST_AMOD;
					end else begin
						cmd.ld_maddr = 1'b1;
						state_d      = ST_MEM;
					end
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_DONE;
			end
			ST_AMOD: begin
				cmd.ld_maddr = 1'b1;
				state_d      = ST_MEM;
			end
			ST_MEM: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				in_ready = out_free;
				if (out_free) begin
					cmd.commit = 1'b1;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_d    = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

### hw/rtl/rie_dp.sv
// Datapath: register file, PC, HI/LO, data memory, ALU, multiplier, divider and result registers.
module rie_dp #(
	parameter int DATA_WORDS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rie_pkg::rie_cmd_t             cmd,
	output rie_pkg::rie_sts_t             sts,
	input  logic [31:0]                   instruction_word,
	output logic [31:0]                   next_pc,
	output logic                          reg_write,
	output logic [4:0]                    reg_index,
	output logic signed [31:0]            reg_value,
	output logic                          mem_write,
	output logic [$clog2(DATA_WORDS)-1:0] mem_word_address,
	output logic signed [31:0]            mem_data,
	output logic signed [31:0]            hi_value,
	output logic signed [31:0]            lo_value,
	output logic                          divide_by_zero
);

	localparam int AW = $clog2(DATA_WORDS);
	localparam bit ADDR_MOD = (DATA_WORDS & (DATA_WORDS - 1)) != 0;
	// Reciprocal of DATA_WORDS, exact for every 30-bit word index.
	localparam int AMOD_SH = 30 + AW;
	localparam logic [63:0] AMOD_M =
		((64'd1 << AMOD_SH) + 64'(DATA_WORDS) - 64'd1) / 64'(DATA_WORDS);

	logic [31:0] rf [32];
	logic [31:0] rfv_q;
	logic [31:0] mem [DATA_WORDS];
	logic [AW-1:0] clr_q;
	logic [AW-1:0] maddr_q;
	logic [31:0] rdata_q;
	logic [31:0] ir_q, a_q, b_q;
	logic [31:0] pc_q, hi_q, lo_q;
	logic [63:0] prod_q;
	logic [61:0] amod_prod_q;

	logic [5:0]  op, fn;
	logic [4:0]  rt, rd, sa, rs_in, rt_in;
	logic [31:0] imm, pc4, br_tgt, j_tgt, eff;
	logic [63:0] rot;
	logic        gt_zero;
	logic [31:0] nxt, wval, hi_n, lo_n;
	logic [4:0]  widx;
	logic        wr, wr_eff, is_ld, is_st, is_div, dz;
	logic        div_done;
	logic [31:0] div_quot, div_rem;
	logic [31-AW:0] amod_quo;
	logic [31:0] amod_rem;

	assign op  = ir_q[31:26];
	assign rt  = ir_q[20:16];
	assign rd  = ir_q[15:11];
	assign sa  = ir_q[10:6];
	assign fn  = ir_q[5:0];
	assign imm = {{16{ir_q[15]}}, ir_q[15:0]};
	assign pc4 = pc_q + 32'd4;
	assign br_tgt = pc4 + {imm[29:0], 2'b00};
	assign j_tgt  = {pc4[31:28], ir_q[25:0], 2'b00};
	assign eff    = a_q + imm;
	assign rot    = {b_q, b_q} >> sa;
	assign gt_zero = !a_q[31] && (a_q != 32'd0);

	always_comb begin
		nxt    = pc4;
		wr     = 1'b0;
		widx   = rd;
		wval   = '0;
		is_ld  = 1'b0;
		is_st  = 1'b0;
		is_div = 1'b0;
		dz     = 1'b0;
		hi_n   = hi_q;
		lo_n   = lo_q;
		case (op)
			rie_pkg::OP_SPECIAL: begin
				case (fn)
					rie_pkg::FN_ADD: begin wr = 1'b1; wval = a_q + b_q; end
					rie_pkg::FN_SUB: begin wr = 1'b1; wval = a_q - b_q; end
					rie_pkg::FN_AND: begin wr = 1'b1; wval = a_q & b_q; end
					rie_pkg::FN_OR:  begin wr = 1'b1; wval = a_q | b_q; end
					rie_pkg::FN_XOR: begin wr = 1'b1; wval = a_q ^ b_q; end
					rie_pkg::FN_SLT: begin
						wr   = 1'b1;
						wval = {31'd0, $signed(a_q) < $signed(b_q)};
					end
					rie_pkg::FN_SLL: begin
						wr   = ir_q != 32'd0;
						wval = b_q << sa;
					end
					rie_pkg::FN_SRL: begin
						wr   = 1'b1;
						wval = ir_q[21] ? rot[31:0] : (b_q >> sa);
					end
					rie_pkg::FN_JR:   nxt = a_q;
					rie_pkg::FN_MFHI: begin wr = 1'b1; wval = hi_q; end
					rie_pkg::FN_MFLO: begin wr = 1'b1; wval = lo_q; end
					rie_pkg::FN_MULT: begin
						hi_n = prod_q[63:32];
						lo_n = prod_q[31:0];
					end
					rie_pkg::FN_DIV: begin
						is_div = 1'b1;
						if (b_q == 32'd0) begin
							dz = 1'b1;
						end else begin
							hi_n = div_rem;
							lo_n = div_quot;
						end
					end
					default: ;
				endcase
			end
			rie_pkg::OP_ADDI: begin wr = 1'b1; widx = rt; wval = eff; end
			rie_pkg::OP_BEQ:  if (a_q == b_q) nxt = br_tgt;
			rie_pkg::OP_BNE:  if (a_q != b_q) nxt = br_tgt;
			rie_pkg::OP_BGTZ: if (gt_zero) nxt = br_tgt;
			rie_pkg::OP_BLEZ: if (!gt_zero) nxt = br_tgt;
			rie_pkg::OP_JAL: begin
				wr   = 1'b1;
				widx = rie_pkg::LINK_REG;
				wval = pc4;
				nxt  = j_tgt;
			end
			rie_pkg::OP_J:   nxt = j_tgt;
			rie_pkg::OP_LUI: begin wr = 1'b1; widx = rt; wval = {ir_q[15:0], 16'd0}; end
			rie_pkg::OP_LW: begin
				is_ld = 1'b1;
				wr    = 1'b1;
				widx  = rt;
				wval  = rdata_q;
			end
			rie_pkg::OP_SW: is_st = 1'b1;
			default: ;
		endcase
	end

	assign wr_eff = wr && (widx != 5'd0);

	rie_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.sgn      (cmd.div_signed),
		.dividend (a_q),
		.divisor  (b_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Word index modulo DATA_WORDS: quotient from the registered reciprocal product.
	assign amod_quo = amod_prod_q[61:AMOD_SH];
	assign amod_rem = {2'b00, eff[31:2]} - 32'(amod_quo) * 32'(DATA_WORDS);

	assign sts.is_div   = is_div;
	assign sts.div_zero = dz;
	assign sts.is_mem   = is_ld || is_st;
	assign sts.addr_mod = ADDR_MOD;
	assign sts.div_done = div_done;
	assign sts.clr_last = clr_q == AW'(DATA_WORDS - 1);

	assign rs_in = instruction_word[25:21];
	assign rt_in = instruction_word[20:16];

	// Register file read at accept, with the write of a committing instruction forwarded.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ir_q <= instruction_word;
			if (cmd.commit && wr_eff && widx == rs_in) a_q <= wval;
			else a_q <= rfv_q[rs_in] ? rf[rs_in] : 32'd0;
			if (cmd.commit && wr_eff && widx == rt_in) b_q <= wval;
			else b_q <= rfv_q[rt_in] ? rf[rt_in] : 32'd0;
		end
		if (cmd.commit && wr_eff) rf[widx] <= wval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rfv_q <= '0;
			pc_q  <= '0;
			hi_q  <= '0;
			lo_q  <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.commit) begin
				if (wr_eff) rfv_q[widx] <= 1'b1;
				pc_q <= nxt;
				hi_q <= hi_n;
				lo_q <= lo_n;
			end
			if (cmd.clr_en) clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			prod_q      <= 64'($signed(a_q) * $signed(b_q));
			amod_prod_q <= {32'd0, eff[31:2]} * {30'd0, AMOD_M[31:0]};
		end
		if (cmd.ld_maddr) maddr_q <= ADDR_MOD ? amod_rem[AW-1:0] : eff[AW+1:2];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) mem[clr_q] <= '0;
		else if (cmd.commit && is_st) mem[maddr_q] <= b_q;
		if (cmd.mem_rd) rdata_q <= mem[maddr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			next_pc          <= nxt;
			reg_write        <= wr_eff;
			reg_index        <= wr_eff ? widx : 5'd0;
			reg_value        <= wr_eff ? wval : 32'd0;
			mem_write        <= is_st;
			mem_word_address <= (is_ld || is_st) ? maddr_q : '0;
			mem_data         <= is_ld ? rdata_q : (is_st ? b_q : 32'd0);
			hi_value         <= hi_n;
			lo_value         <= lo_n;
			divide_by_zero   <= dz;
		end
	end

endmodule

### hw/rtl/rie_chk.sv
// Port-level checker of the execute step and its bind to the top level.
module rie_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] next_pc,
	input logic        reg_write,
	input logic [4:0]  reg_index,
	input logic [31:0] reg_value,
	input logic        mem_write,
	input logic        divide_by_zero
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(reg_value))
		else $error("result changed while stalled");

	a_no_r0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_write |-> reg_index != 5'd0)
		else $error("write to register zero reported");

	a_no_wr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_write |-> reg_index == 5'd0 && reg_value == 32'd0)
		else $error("register fields not zero without a write");

	a_store_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mem_write |-> !reg_write && !divide_by_zero)
		else $error("store reported other effects");

endmodule

bind risc_integer_execute_step_top rie_chk u_rie_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.next_pc        (next_pc),
	.reg_write      (reg_write),
	.reg_index      (reg_index),
	.reg_value      (reg_value),
	.mem_write      (mem_write),
	.divide_by_zero (divide_by_zero)
);

### dv/tb_risc_integer_execute_step_top.sv
// Self-checking testbench of the integer execute step: directed and random instruction requests.

// Architectural effect of one instruction, as the block reports it.
typedef struct {
	logic [31:0] next_pc;
	logic        reg_write;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;
	logic        mem_write;
	logic [9:0]  mem_word_address;
	logic [31:0] mem_data;
	logic [31:0] hi_value;
	logic [31:0] lo_value;
	logic        divide_by_zero;
} step_effect_t;

// Predicts the architectural effect of each instruction and checks the block's results.
class exec_scoreboard;
	logic [31:0] gpr [32];
	logic [31:0] pc, hi, lo;
	logic [31:0] dmem [1024];
	step_effect_t pending_effects[$];
	int errors;
	int checked;
	int n_div_zero, n_taken, n_mem;

	function new();
		foreach (gpr[i]) gpr[i] = '0;
		foreach (dmem[i]) dmem[i] = '0;
		pc = '0;
		hi = '0;
		lo = '0;
		errors = 0;
		checked = 0;
		n_div_zero = 0;
		n_taken = 0;
		n_mem = 0;
	endfunction

	function void note_instruction(logic [31:0] w);
		step_effect_t e;
		logic [5:0] op, fn;
		logic [4:0] rs, rt, rd, sa;
		logic [31:0] imm, a, b, pc4, target, ea;
		logic signed [63:0] prod;
		logic signed [31:0] q, r;
		op = w[31:26];
		rs = w[25:21];
		rt = w[20:16];
		rd = w[15:11];
		sa = w[10:6];
		fn = w[5:0];
		imm = {{16{w[15]}}, w[15:0]};
		a = gpr[rs];
		b = gpr[rt];
		pc4 = pc + 32'd4;
		target = pc4 + (imm << 2);
		ea = a + imm;
		e = '{next_pc: pc4, default: '0};
		if (op != rie_pkg::OP_SPECIAL) begin
			case (op)
				rie_pkg::OP_ADDI: begin
					e.reg_write = 1; e.reg_index = rt; e.reg_value = a + imm;
				end
				rie_pkg::OP_BEQ:  if (a == b) e.next_pc = target;
				rie_pkg::OP_BNE:  if (a != b) e.next_pc = target;
				rie_pkg::OP_BGTZ: if ($signed(a) > 0) e.next_pc = target;
				rie_pkg::OP_BLEZ: if ($signed(a) <= 0) e.next_pc = target;
				rie_pkg::OP_JAL: begin
					e.reg_write = 1; e.reg_index = rie_pkg::LINK_REG; e.reg_value = pc4;
					e.next_pc = {pc4[31:28], w[25:0], 2'b00};
				end
				rie_pkg::OP_J:    e.next_pc = {pc4[31:28], w[25:0], 2'b00};
				rie_pkg::OP_LUI: begin
					e.reg_write = 1; e.reg_index = rt; e.reg_value = {w[15:0], 16'h0};
				end
				rie_pkg::OP_LW: begin
					e.mem_word_address = ea[11:2];
					e.mem_data = dmem[ea[11:2]];
					e.reg_write = 1; e.reg_index = rt; e.reg_value = e.mem_data;
					n_mem++;
				end
				rie_pkg::OP_SW: begin
					e.mem_word_address = ea[11:2];
					e.mem_data = b;
					e.mem_write = 1;
					dmem[ea[11:2]] = b;
					n_mem++;
				end
				default: ;
			endcase
		end else begin
			case (fn)
				rie_pkg::FN_ADD: begin e.reg_write = 1; e.reg_index = rd; e.reg_value = a + b; end
				rie_pkg::FN_SUB: begin e.reg_write = 1; e.reg_index = rd; e.reg_value = a - b; end
				rie_pkg::FN_AND: begin e.reg_write = 1; e.reg_index = rd; e.reg_value = a & b; end
				rie_pkg::FN_OR:  begin e.reg_write = 1; e.reg_index = rd; e.reg_value = a | b; end
				rie_pkg::FN_XOR: begin e.reg_write = 1; e.reg_index = rd; e.reg_value = a ^ b; end
				rie_pkg::FN_SLT: begin
					e.reg_write = 1; e.reg_index = rd;
					e.reg_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
				end
				rie_pkg::FN_SLL: if (w != '0) begin
					e.reg_write = 1; e.reg_index = rd; e.reg_value = b << sa;
				end
				rie_pkg::FN_SRL: begin
					e.reg_write = 1; e.reg_index = rd;
					if (w[21]) e.reg_value = (sa == 0) ? b : ((b >> sa) | (b << (6'd32 - sa)));
					else e.reg_value = b >> sa;
				end
				rie_pkg::FN_JR:   e.next_pc = a;
				rie_pkg::FN_MFHI: begin e.reg_write = 1; e.reg_index = rd; e.reg_value = hi; end
				rie_pkg::FN_MFLO: begin e.reg_write = 1; e.reg_index = rd; e.reg_value = lo; end
				rie_pkg::FN_MULT: begin
					prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
					hi = prod[63:32];
					lo = prod[31:0];
				end
				rie_pkg::FN_DIV: begin
					if (b == '0) begin
						e.divide_by_zero = 1;
						n_div_zero++;
					end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
						// The one quotient that does not fit wraps to itself.
						lo = a;
						hi = '0;
					end else begin
						q = $signed(a) / $signed(b);
						r = $signed(a) % $signed(b);
						lo = q;
						hi = r;
					end
				end
				default: ;
			endcase
		end
		if (e.reg_write && e.reg_index == 5'd0) begin
			e.reg_write = 0;
			e.reg_value = '0;
		end
		if (e.reg_write) gpr[e.reg_index] = e.reg_value;
		else e.reg_index = '0;
		if (e.next_pc != pc4) n_taken++;
		pc = e.next_pc;
		e.hi_value = hi;
		e.lo_value = lo;
		pending_effects.push_back(e);
	endfunction

	function void report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH result %0d: %s got %h expected %h", checked, what, got, want);
		errors++;
	endfunction

	function void check_result(step_effect_t got);
		step_effect_t want;
		if (pending_effects.size() == 0) begin
			report("result with no pending request, next_pc", got.next_pc, '0);
			return;
		end
		want = pending_effects.pop_front();
		if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
		if (got.reg_write !== want.reg_write) report("reg_write", got.reg_write, want.reg_write);
		if (got.reg_index !== want.reg_index) report("reg_index", got.reg_index, want.reg_index);
		if (got.reg_value !== want.reg_value) report("reg_value", got.reg_value, want.reg_value);
		if (got.mem_write !== want.mem_write) report("mem_write", got.mem_write, want.mem_write);
		if (got.mem_word_address !== want.mem_word_address)
			report("mem_word_address", got.mem_word_address, want.mem_word_address);
		if (got.mem_data !== want.mem_data) report("mem_data", got.mem_data, want.mem_data);
		if (got.hi_value !== want.hi_value) report("hi_value", got.hi_value, want.hi_value);
		if (got.lo_value !== want.lo_value) report("lo_value", got.lo_value, want.lo_value);
		if (got.divide_by_zero !== want.divide_by_zero)
			report("divide_by_zero", got.divide_by_zero, want.divide_by_zero);
		checked++;
	endfunction
endclass

module tb_risc_integer_execute_step_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] instruction_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] next_pc;
	logic        reg_write;
	logic [4:0]  reg_index;
	logic signed [31:0] reg_value;
	logic        mem_write;
	logic [9:0]  mem_word_address;
	logic signed [31:0] mem_data;
	logic signed [31:0] hi_value;
	logic signed [31:0] lo_value;
	logic        divide_by_zero;

	exec_scoreboard sb;
	int sent;
	// While set, the result side refuses everything so that the block backs up.
	bit hold_results;

	risc_integer_execute_step_top #(.DATA_WORDS(1024)) DUT (.*);

	// A 10 ns clock, five high and five low.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mostly short gaps with the occasional long one; a third of the time none at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request and hold it steady until the block takes it.
	task automatic send_instruction(logic [31:0] w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		instruction_word <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// The request is accepted at this edge, so predict its effect now.
		sb.note_instruction(w);
		sent++;
	endtask

	function automatic logic [31:0] r_type(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
			logic [4:0] sa, logic [5:0] fn);
		return {rie_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	// Branch and jump offsets are random, so the PC wanders, which is harmless
	// here since the instruction stream does not depend on the PC.
	function automatic logic [31:0] random_instruction();
		logic [5:0] ops [11];
		logic [5:0] fns [16];
		logic [4:0] rs, rt, rd, sa;
		logic [15:0] imm;
		int pick;
		ops = '{rie_pkg::OP_ADDI, rie_pkg::OP_ADDI, rie_pkg::OP_LUI, rie_pkg::OP_LW,
			rie_pkg::OP_SW, rie_pkg::OP_BEQ, rie_pkg::OP_BNE, rie_pkg::OP_BGTZ,
			rie_pkg::OP_BLEZ, rie_pkg::OP_J, rie_pkg::OP_JAL};
		fns = '{rie_pkg::FN_ADD, rie_pkg::FN_SUB, rie_pkg::FN_AND, rie_pkg::FN_OR,
			rie_pkg::FN_XOR, rie_pkg::FN_SLT, rie_pkg::FN_SLL, rie_pkg::FN_SRL,
			rie_pkg::FN_SRL, rie_pkg::FN_JR, rie_pkg::FN_MFHI, rie_pkg::FN_MFLO,
			rie_pkg::FN_MULT, rie_pkg::FN_MULT, rie_pkg::FN_DIV, rie_pkg::FN_DIV};
		// Low registers are reused so that values flow between instructions.
		rs = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
		rt = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
		rd = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 7));
		sa = 5'($urandom);
		imm = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 4) return $urandom;
		if (pick < 50) begin
			logic [31:0] w;
			w = r_type(rs, rt, rd, sa, fns[$urandom_range(0, 15)]);
			// Junk in the rs field of shifts must be ignored apart from the rotate bit.
			if (w[5:0] == rie_pkg::FN_SRL || w[5:0] == rie_pkg::FN_SLL) w[25:21] = 5'($urandom);
			return w;
		end
		return i_type(ops[$urandom_range(0, 10)], rs, rt, imm);
	endfunction

	// Register values are set up, then the special cases are hit once each.
	task automatic run_directed();
		send_instruction(32'h0000_0000);
		send_instruction(i_type(rie_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000));
		send_instruction(i_type(rie_pkg::OP_ADDI, 5'd0, 5'd2, 16'hFFFF));
		send_instruction(i_type(rie_pkg::OP_LUI, 5'd0, 5'd3, 16'h7FFF));
		send_instruction(i_type(rie_pkg::OP_ADDI, 5'd3, 5'd3, 16'h7FFF));
		send_instruction(i_type(rie_pkg::OP_ADDI, 5'd3, 5'd3, 16'h7FFF));
		send_instruction(r_type(5'd3, 5'd3, 5'd4, 5'd0, rie_pkg::FN_ADD));
		send_instruction(r_type(5'd1, 5'd2, 5'd5, 5'd0, rie_pkg::FN_SUB));
		send_instruction(r_type(5'd1, 5'd2, 5'd6, 5'd0, rie_pkg::FN_SLT));
		send_instruction(r_type(5'd0, 5'd1, 5'd0, 5'd0, rie_pkg::FN_AND));
		send_instruction(r_type(5'd1, 5'd2, 5'd0, 5'd0, rie_pkg::FN_DIV));
		send_instruction(r_type(5'd1, 5'd0, 5'd0, 5'd0, rie_pkg::FN_DIV));
		send_instruction(r_type(5'd1, 5'd1, 5'd0, 5'd0, rie_pkg::FN_MULT));
		send_instruction(r_type(5'd0, 5'd0, 5'd7, 5'd0, rie_pkg::FN_MFHI));
		send_instruction(r_type(5'd0, 5'd0, 5'd8, 5'd0, rie_pkg::FN_MFLO));
		send_instruction(r_type(5'd31, 5'd2, 5'd9, 5'd0, rie_pkg::FN_SRL));
		send_instruction(r_type(5'd1, 5'd2, 5'd9, 5'd31, rie_pkg::FN_SRL));
		send_instruction(r_type(5'd0, 5'd1, 5'd10, 5'd0, rie_pkg::FN_SRL) | 32'h0020_0000);
		send_instruction(r_type(5'd0, 5'd2, 5'd10, 5'd31, rie_pkg::FN_SLL));
		send_instruction(i_type(rie_pkg::OP_SW, 5'd2, 5'd1, 16'h8001));
		send_instruction(i_type(rie_pkg::OP_LW, 5'd2, 5'd11, 16'h8001));
		send_instruction(i_type(rie_pkg::OP_JAL, 5'd31, 5'd31, 16'hFFFF));
		send_instruction(r_type(5'd0, 5'd0, 5'd0, 5'd0, rie_pkg::FN_SYSCALL));
		send_instruction({6'd63, 26'h3FF_FFFF});
		send_instruction(r_type(5'd31, 5'd0, 5'd0, 5'd0, rie_pkg::FN_JR));
	endtask

	// Result side: random readiness, plus one long refusal driven by the stimulus.
	initial begin
		step_effect_t got;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.next_pc = next_pc;
				got.reg_write = reg_write;
				got.reg_index = reg_index;
				got.reg_value = reg_value;
				got.mem_write = mem_write;
				got.mem_word_address = mem_word_address;
				got.mem_data = mem_data;
				got.hi_value = hi_value;
				got.lo_value = lo_value;
				got.divide_by_zero = divide_by_zero;
				sb.check_result(got);
			end
			if (hold_results) out_ready <= 1'b0;
			else if ($urandom_range(0, 99) < 8) out_ready <= 1'b0;
			else out_ready <= 1'b1;
		end
	end

	// The long hold-off counts its own cycles while requests keep coming.
	initial begin
		hold_results = 1'b0;
		wait (sent >= 300);
		@(posedge clk);
		hold_results = 1'b1;
		repeat (150) @(posedge clk);
		hold_results = 1'b0;
	end

	initial begin
		sb = new();
		sent = 0;
		in_valid = 1'b0;
		instruction_word = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		repeat (1025) send_instruction(random_instruction());
		in_valid <= 1'b0;
		while (sb.pending_effects.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Ran %0d instructions, %0d results checked: %0d memory accesses,",
			sent, sb.checked, sb.n_mem);
		$display("%0d taken branches or jumps, %0d divides by zero.", sb.n_taken, sb.n_div_zero);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Slowest run is about 1050 divides plus the clearing pass.
	initial begin
		#5ms;
		$display("Timeout after %0d requests", sent);
		$display("Test completed with failures");
		$finish;
	end
endmodule
